@@ src/wep_pkg.sv @@
// Shared types and constants for the wall edge perspective projection unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package wep_pkg;

	localparam int SCREEN_WIDTH_DEF  = 320;
	localparam int SCREEN_HEIGHT_DEF = 200;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_COS      = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SIN      = CFG_IDX_W'(3);

	localparam int WORLD_W = 32;
	localparam int ANG_W   = 16;
	localparam int ANG_FRAC = 14;
	localparam int Q_FRAC  = 16;
	localparam int SCR_W   = 16;
	localparam int DEPTH_SCALE = 60;

	localparam int PW   = WORLD_W + 1;        // camera-relative vertex
	localparam int CW   = 2 * PW + 1;         // cull cross product
	localparam int RW   = PW + ANG_W;         // rotation product
	localparam int SW   = RW + 1;             // rotation sum
	localparam int XW   = SW - ANG_FRAC;      // camera-space coordinate
	localparam int EW   = XW + 1;             // edge delta
	localparam int MW   = 2 * XW;             // vertex product
	localparam int ABW  = MW + 1;             // vertex cross
	localparam int DETW = 60;                 // determinant
	localparam int NUMW = 96;                 // intersection numerator and result
	localparam int PRW  = 116;                // projection operands
	localparam int KW   = 25;                 // side line constants

	localparam int QDEPTH = 4;

	// side lines (-e,e)-(-20,5) and (e,e)-(20,5) in Q16.16, with e = 7 LSBs
	localparam logic signed [KW-1:0] FX_L  = KW'(1310713);
	localparam logic signed [KW-1:0] FZ_L  = -KW'(327673);
	localparam logic signed [KW-1:0] PCD_L = KW'(6881280);
	localparam logic signed [KW-1:0] FX_R  = -KW'(1310713);
	localparam logic signed [KW-1:0] FZ_R  = -KW'(327673);
	localparam logic signed [KW-1:0] PCD_R = -KW'(6881280);

	typedef struct packed {
		logic                   kill;
		logic                   last;
		logic signed [PW-1:0]   h;
		logic signed [XW-1:0]   x1;
		logic signed [XW-1:0]   z1;
		logic signed [XW-1:0]   x2;
		logic signed [XW-1:0]   z2;
	} wep_item_t;

endpackage
`default_nettype wire

@@ src/wall_edge_perspective_project_unit.sv @@
// An edge passes through the front, the queue, intersection setup, the intersection
// divide, clip and projection setup, the screen divide and the result register.
// Throughput: one edge per cycle while out_stall does not hold the pipeline; the
// bit-per-stage dividers are fully pipelined.
// Reset clears all valids, the queue and the camera registers
// (position 0, cos 16384, sin 0); configuration is always ready.
`default_nettype none
module wall_edge_perspective_project_unit import wep_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [WORLD_W-1:0]  start_x,
	input  logic signed [WORLD_W-1:0]  start_y,
	input  logic signed [WORLD_W-1:0]  end_x,
	input  logic signed [WORLD_W-1:0]  end_y,
	input  logic signed [WORLD_W-1:0]  wall_height,
	input  logic                       last_edge,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       visible,
	output logic signed [SCR_W-1:0]    left_x,
	output logic signed [SCR_W-1:0]    right_x,
	output logic signed [SCR_W-1:0]    left_top,
	output logic signed [SCR_W-1:0]    left_bottom,
	output logic signed [SCR_W-1:0]    right_top,
	output logic signed [SCR_W-1:0]    right_bottom,
	output logic                       edge_last
);
	logic      push, pop, q_full, q_empty;
	wep_item_t push_item, pop_item;

	assign cfg_ready = 1'b1;

	wep_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.wall_height(wall_height), .last_edge(last_edge),
		.q_full(q_full), .push(push), .push_item(push_item)
	);

	wep_fifo #(.DEPTH(QDEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_item(push_item),
		.pop(pop), .pop_item(pop_item),
		.full(q_full), .empty(q_empty)
	);

	wep_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_item(pop_item), .q_empty(q_empty), .q_pop(pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.visible(visible), .left_x(left_x), .right_x(right_x),
		.left_top(left_top), .left_bottom(left_bottom),
		.right_top(right_top), .right_bottom(right_bottom),
		.edge_last(edge_last)
	);
endmodule
`default_nettype wire

@@ src/wep_fifo.sv @@
// Short queue of classified edges between the front and back parts.
// Depends on wep_pkg for the item type.
`default_nettype none
module wep_fifo import wep_pkg::*; #(
	parameter int DEPTH = QDEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  wep_item_t push_item,
	input  logic      pop,
	output wep_item_t pop_item,
	output logic      full,
	output logic      empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	wep_item_t       mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] cnt_q;

	assign full     = (cnt_q == CNTW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

@@ src/wep_front.sv @@
// Front part: configuration registers, camera-relative vertices, cull test,
// rotation into camera space and behind-camera test. Depends on wep_pkg.
`default_nettype none
module wep_front import wep_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [WORLD_W-1:0]  start_x,
	input  logic signed [WORLD_W-1:0]  start_y,
	input  logic signed [WORLD_W-1:0]  end_x,
	input  logic signed [WORLD_W-1:0]  end_y,
	input  logic signed [WORLD_W-1:0]  wall_height,
	input  logic                       last_edge,
	input  logic                       q_full,
	output logic                       push,
	output wep_item_t                  push_item
);
	localparam logic signed [CW-1:0] CULL_LIM = CW'(64'h1_0000_0000);

	logic signed [WORLD_W-1:0] camera_x_q, camera_y_q;
	logic signed [ANG_W-1:0]   cos_q, sin_q;

	logic adv;
	logic v_s1, v_s2, v_s3;
	logic signed [PW-1:0] p1x_s1, p1y_s1, p2x_s1, p2y_s1, h_s1;
	logic last_s1, last_s2;
	logic signed [PW-1:0] h_s2;
	logic signed [CW-1:0] ca_s2, cb_s2;
	logic signed [RW-1:0] a1c_s2, a1s_s2, b1s_s2, b1c_s2;
	logic signed [RW-1:0] a2c_s2, a2s_s2, b2s_s2, b2c_s2;
	wep_item_t item_s3;

	logic signed [CW-1:0] cr;
	logic signed [SW-1:0] zs1, xs1, zs2, xs2;
	logic signed [XW-1:0] z1, x1, z2, x2;

	assign in_stall  = v_s3 && q_full;
	assign adv       = !in_stall;
	assign push      = v_s3 && !q_full;
	assign push_item = item_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			camera_x_q <= '0;
			camera_y_q <= '0;
			cos_q      <= ANG_W'(16384);
			sin_q      <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CAMERA_X: camera_x_q <= cfg_data;
				REG_CAMERA_Y: camera_y_q <= cfg_data;
				REG_COS:      cos_q      <= cfg_data[ANG_W-1:0];
				REG_SIN:      sin_q      <= cfg_data[ANG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		cr  = ca_s2 - cb_s2;
		zs1 = SW'(a1c_s2) + SW'(b1s_s2);
		xs1 = SW'(a1s_s2) - SW'(b1c_s2);
		zs2 = SW'(a2c_s2) + SW'(b2s_s2);
		xs2 = SW'(a2s_s2) - SW'(b2c_s2);
		z1  = XW'(zs1 >>> ANG_FRAC);
		x1  = XW'(xs1 >>> ANG_FRAC);
		z2  = XW'(zs2 >>> ANG_FRAC);
		x2  = XW'(xs2 >>> ANG_FRAC);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1x_s1  <= PW'(start_x) - PW'(camera_x_q);
			p1y_s1  <= PW'(start_y) - PW'(camera_y_q);
			p2x_s1  <= PW'(end_x) - PW'(camera_x_q);
			p2y_s1  <= PW'(end_y) - PW'(camera_y_q);
			h_s1    <= -PW'(wall_height);
			last_s1 <= last_edge;

			ca_s2   <= CW'(p1x_s1) * CW'(p2y_s1);
			cb_s2   <= CW'(p1y_s1) * CW'(p2x_s1);
			a1c_s2  <= RW'(p1x_s1) * RW'(cos_q);
			b1s_s2  <= RW'(p1y_s1) * RW'(sin_q);
			a1s_s2  <= RW'(p1x_s1) * RW'(sin_q);
			b1c_s2  <= RW'(p1y_s1) * RW'(cos_q);
			a2c_s2  <= RW'(p2x_s1) * RW'(cos_q);
			b2s_s2  <= RW'(p2y_s1) * RW'(sin_q);
			a2s_s2  <= RW'(p2x_s1) * RW'(sin_q);
			b2c_s2  <= RW'(p2y_s1) * RW'(cos_q);
			h_s2    <= h_s1;
			last_s2 <= last_s1;

			item_s3.kill <= (cr >= CULL_LIM) || ((z1 <= 0) && (z2 <= 0));
			item_s3.last <= last_s2;
			item_s3.h    <= h_s2;
			item_s3.x1   <= x1;
			item_s3.z1   <= z1;
			item_s3.x2   <= x2;
			item_s3.z2   <= z2;
		end
	end
endmodule
`default_nettype wire

@@ src/wep_sdiv.sv @@
// Pipelined signed truncating divider, one quotient bit per stage.
// A zero divisor gives zero. Depends on wep_pkg for its parameter defaults.
`default_nettype none
module wep_sdiv import wep_pkg::*; #(
	parameter int NW = NUMW,
	parameter int DW = DETW
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic signed [NW-1:0] quo
);
	logic [NW-1:0] nq_q  [NW+1];
	logic [DW-1:0] rem_q [NW+1];
	logic [DW-1:0] ad_q  [NW+1];
	logic          neg_q [NW+1];
	logic          dz_q  [NW+1];

	logic [DW:0]   trial [NW];
	logic          ge    [NW];
	logic [DW-1:0] rem_nx[NW];

	always_comb begin
		for (int k = 0; k < NW; k++) begin
			trial[k]  = {rem_q[k], nq_q[k][NW-1]};
			ge[k]     = trial[k] >= {1'b0, ad_q[k]};
			rem_nx[k] = ge[k] ? DW'(trial[k] - {1'b0, ad_q[k]}) : DW'(trial[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nq_q[0]  <= num[NW-1] ? NW'(-num) : NW'(num);
			ad_q[0]  <= den[DW-1] ? DW'(-den) : DW'(den);
			rem_q[0] <= '0;
			neg_q[0] <= num[NW-1] ^ den[DW-1];
			dz_q[0]  <= (den == '0);
			for (int k = 0; k < NW; k++) begin
				nq_q[k+1]  <= {nq_q[k][NW-2:0], ge[k]};
				rem_q[k+1] <= rem_nx[k];
				ad_q[k+1]  <= ad_q[k];
				neg_q[k+1] <= neg_q[k];
				dz_q[k+1]  <= dz_q[k];
			end
		end
	end

	always_comb begin
		if (dz_q[NW]) begin
			quo = '0;
		end else if (neg_q[NW]) begin
			quo = -$signed(nq_q[NW]);
		end else begin
			quo = $signed(nq_q[NW]);
		end
	end
endmodule
`default_nettype wire

@@ src/wep_satdiv.sv @@
// Pipelined signed truncating divider with a 16 bit saturated quotient.
// Zero divisor saturates toward the numerator's sign; zero over zero gives zero. Depends on wep_pkg.
`default_nettype none
module wep_satdiv import wep_pkg::*; #(
	parameter int NW = PRW
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [NW-1:0]    num,
	input  logic signed [NW-1:0]    den,
	output logic signed [SCR_W-1:0] quo
);
	localparam int QB = SCR_W - 1;
	localparam int WW = NW + QB;

	logic [NW-1:0] an_q, ad0_q;
	logic          neg0_q, both0_q;

	logic [WW-1:0] rem_q [QB+1];
	logic [NW-1:0] ad_q  [QB+1];
	logic [QB-1:0] q_q   [QB+1];
	logic          neg_q [QB+1];
	logic          zz_q  [QB+1];
	logic          sat_q [QB+1];

	logic [WW-1:0] dsh   [QB];
	logic          ge    [QB];

	always_comb begin
		for (int k = 0; k < QB; k++) begin
			dsh[k] = WW'(ad_q[k]) << (QB - 1 - k);
			ge[k]  = rem_q[k] >= dsh[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			an_q    <= num[NW-1] ? NW'(-num) : NW'(num);
			ad0_q   <= den[NW-1] ? NW'(-den) : NW'(den);
			neg0_q  <= num[NW-1] ^ den[NW-1];
			both0_q <= (num == '0) && (den == '0);

			rem_q[0] <= WW'(an_q);
			ad_q[0]  <= ad0_q;
			q_q[0]   <= '0;
			neg_q[0] <= neg0_q;
			zz_q[0]  <= both0_q;
			sat_q[0] <= WW'(an_q) >= (WW'(ad0_q) << QB);
			for (int k = 0; k < QB; k++) begin
				rem_q[k+1] <= ge[k] ? rem_q[k] - dsh[k] : rem_q[k];
				ad_q[k+1]  <= ad_q[k];
				q_q[k+1]   <= {q_q[k][QB-2:0], ge[k]};
				neg_q[k+1] <= neg_q[k];
				zz_q[k+1]  <= zz_q[k];
				sat_q[k+1] <= sat_q[k];
			end
		end
	end

	always_comb begin
		if (zz_q[QB]) begin
			quo = '0;
		end else if (sat_q[QB]) begin
			quo = neg_q[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
		end else if (neg_q[QB]) begin
			quo = -$signed({1'b0, q_q[QB]});
		end else begin
			quo = $signed({1'b0, q_q[QB]});
		end
	end
endmodule
`default_nettype wire

@@ src/wep_back.sv @@
// Back part: side line intersections, clip choice, perspective divide and
// result register. Depends on wep_pkg, wep_sdiv and wep_satdiv.
`default_nettype none
module wep_back import wep_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  wep_item_t               q_item,
	input  logic                    q_empty,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    visible,
	output logic signed [SCR_W-1:0] left_x,
	output logic signed [SCR_W-1:0] right_x,
	output logic signed [SCR_W-1:0] left_top,
	output logic signed [SCR_W-1:0] left_bottom,
	output logic signed [SCR_W-1:0] right_top,
	output logic signed [SCR_W-1:0] right_bottom,
	output logic                    edge_last
);
	localparam int LDIV = NUMW + 1;
	localparam int LSAT = SCR_W + 1;
	localparam logic signed [PRW-1:0] W_C    = PRW'(SCREEN_WIDTH);
	localparam logic signed [PRW-1:0] HT_C   = PRW'(DEPTH_SCALE * SCREEN_HEIGHT);
	localparam logic signed [PRW-1:0] DEN_C  = PRW'(2 * DEPTH_SCALE);
	localparam logic signed [PRW-1:0] BASE_C = PRW'(2 * SCREEN_WIDTH * SCREEN_HEIGHT) <<< Q_FRAC;

	logic adv;
	logic out_valid_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	wep_item_t it_s1, it_s2, it_s3;
	logic signed [EW-1:0]   ex_s1, ez_s1, ex_s2, ez_s2;
	logic signed [MW-1:0]   m1_s1, m2_s1;
	logic signed [ABW-1:0]  pab_s2;
	logic signed [DETW-1:0] detl_s2, detr_s2, detl_s3, detr_s3;
	logic signed [NUMW-1:0] expl_s2, expr_s2, ezpl_s2, ezpr_s2;
	logic signed [NUMW-1:0] nxl_s3, nzl_s3, nxr_s3, nzr_s3;

	logic signed [NUMW-1:0] ixl, izl, ixr, izr;
	wep_item_t dly_it_q [LDIV];
	logic      dly_v_q  [LDIV];
	wep_item_t it_d;

	logic signed [NUMW-1:0] cx1, cz1, cx2, cz2;
	logic use_l;
	logic signed [NUMW-1:0] x1_s4, z1_s4, x2_s4, z2_s4;
	logic signed [PW-1:0]   h_s4;
	logic                   kill_s4, last_s4;

	logic signed [PRW-1:0] sxn1_s5, sxd1_s5, tn1_s5, bn1_s5, dn1_s5;
	logic signed [PRW-1:0] sxn2_s5, sxd2_s5, tn2_s5, bn2_s5, dn2_s5;
	logic                  kill_s5, last_s5;

	logic sv_q [LSAT];
	logic sk_q [LSAT];
	logic sl_q [LSAT];
	logic signed [SCR_W-1:0] r_lx, r_rx, r_lt, r_lb, r_rt, r_rb;

	assign adv       = !(out_valid_q && out_stall);
	assign q_pop     = adv && !q_empty;
	assign out_valid = out_valid_q;
	assign it_d      = dly_it_q[LDIV-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int k = 0; k < LDIV; k++) begin
				dly_v_q[k] <= 1'b0;
			end
			for (int k = 0; k < LSAT; k++) begin
				sv_q[k] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			dly_v_q[0] <= v_s3;
			for (int k = 1; k < LDIV; k++) begin
				dly_v_q[k] <= dly_v_q[k-1];
			end
			v_s4 <= dly_v_q[LDIV-1];
			v_s5 <= v_s4;
			sv_q[0] <= v_s5;
			for (int k = 1; k < LSAT; k++) begin
				sv_q[k] <= sv_q[k-1];
			end
			out_valid_q <= sv_q[LSAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1 <= q_item;
			ex_s1 <= EW'(q_item.x1) - EW'(q_item.x2);
			ez_s1 <= EW'(q_item.z1) - EW'(q_item.z2);
			m1_s1 <= MW'(q_item.x1) * MW'(q_item.z2);
			m2_s1 <= MW'(q_item.z1) * MW'(q_item.x2);

			it_s2   <= it_s1;
			ex_s2   <= ex_s1;
			ez_s2   <= ez_s1;
			pab_s2  <= ABW'(m1_s1) - ABW'(m2_s1);
			detl_s2 <= DETW'(ex_s1) * DETW'(FZ_L) - DETW'(ez_s1) * DETW'(FX_L);
			detr_s2 <= DETW'(ex_s1) * DETW'(FZ_R) - DETW'(ez_s1) * DETW'(FX_R);
			expl_s2 <= NUMW'(ex_s1) * NUMW'(PCD_L);
			expr_s2 <= NUMW'(ex_s1) * NUMW'(PCD_R);
			ezpl_s2 <= NUMW'(ez_s1) * NUMW'(PCD_L);
			ezpr_s2 <= NUMW'(ez_s1) * NUMW'(PCD_R);

			it_s3   <= it_s2;
			detl_s3 <= detl_s2;
			detr_s3 <= detr_s2;
			nxl_s3  <= NUMW'(pab_s2) * NUMW'(FX_L) - expl_s2;
			nzl_s3  <= NUMW'(pab_s2) * NUMW'(FZ_L) - ezpl_s2;
			nxr_s3  <= NUMW'(pab_s2) * NUMW'(FX_R) - expr_s2;
			nzr_s3  <= NUMW'(pab_s2) * NUMW'(FZ_R) - ezpr_s2;

			dly_it_q[0] <= it_s3;
			for (int k = 1; k < LDIV; k++) begin
				dly_it_q[k] <= dly_it_q[k-1];
			end

			x1_s4   <= cx1;
			z1_s4   <= cz1;
			x2_s4   <= cx2;
			z2_s4   <= cz2;
			h_s4    <= it_d.h;
			kill_s4 <= it_d.kill;
			last_s4 <= it_d.last;

			sxn1_s5 <= W_C * (PRW'(z1_s4) - PRW'(x1_s4));
			sxd1_s5 <= PRW'(z1_s4) <<< 1;
			tn1_s5  <= DEN_C * PRW'(h_s4) - BASE_C + HT_C * PRW'(z1_s4);
			bn1_s5  <= BASE_C + HT_C * PRW'(z1_s4);
			dn1_s5  <= DEN_C * PRW'(z1_s4);
			sxn2_s5 <= W_C * (PRW'(z2_s4) - PRW'(x2_s4));
			sxd2_s5 <= PRW'(z2_s4) <<< 1;
			tn2_s5  <= DEN_C * PRW'(h_s4) - BASE_C + HT_C * PRW'(z2_s4);
			bn2_s5  <= BASE_C + HT_C * PRW'(z2_s4);
			dn2_s5  <= DEN_C * PRW'(z2_s4);
			kill_s5 <= kill_s4;
			last_s5 <= last_s4;

			sk_q[0] <= kill_s5;
			sl_q[0] <= last_s5;
			for (int k = 1; k < LSAT; k++) begin
				sk_q[k] <= sk_q[k-1];
				sl_q[k] <= sl_q[k-1];
			end

			visible      <= !sk_q[LSAT-1];
			edge_last    <= sl_q[LSAT-1];
			left_x       <= sk_q[LSAT-1] ? '0 : r_lx;
			right_x      <= sk_q[LSAT-1] ? '0 : r_rx;
			left_top     <= sk_q[LSAT-1] ? '0 : r_lt;
			left_bottom  <= sk_q[LSAT-1] ? '0 : r_lb;
			right_top    <= sk_q[LSAT-1] ? '0 : r_rt;
			right_bottom <= sk_q[LSAT-1] ? '0 : r_rb;
		end
	end

	wep_sdiv #(.NW(NUMW), .DW(DETW)) u_div_xl (
		.clk(clk), .en(adv), .num(nxl_s3), .den(detl_s3), .quo(ixl));
	wep_sdiv #(.NW(NUMW), .DW(DETW)) u_div_zl (
		.clk(clk), .en(adv), .num(nzl_s3), .den(detl_s3), .quo(izl));
	wep_sdiv #(.NW(NUMW), .DW(DETW)) u_div_xr (
		.clk(clk), .en(adv), .num(nxr_s3), .den(detr_s3), .quo(ixr));
	wep_sdiv #(.NW(NUMW), .DW(DETW)) u_div_zr (
		.clk(clk), .en(adv), .num(nzr_s3), .den(detr_s3), .quo(izr));

	always_comb begin
		use_l = izl > 0;
		cx1 = NUMW'(it_d.x1);
		cz1 = NUMW'(it_d.z1);
		cx2 = NUMW'(it_d.x2);
		cz2 = NUMW'(it_d.z2);
		if (it_d.z1 <= 0) begin
			cx1 = use_l ? ixl : ixr;
			cz1 = use_l ? izl : izr;
		end
		if (it_d.z2 <= 0) begin
			cx2 = use_l ? ixl : ixr;
			cz2 = use_l ? izl : izr;
		end
	end

	wep_satdiv #(.NW(PRW)) u_sd_lx (
		.clk(clk), .en(adv), .num(sxn1_s5), .den(sxd1_s5), .quo(r_lx));
	wep_satdiv #(.NW(PRW)) u_sd_lt (
		.clk(clk), .en(adv), .num(tn1_s5), .den(dn1_s5), .quo(r_lt));
	wep_satdiv #(.NW(PRW)) u_sd_lb (
		.clk(clk), .en(adv), .num(bn1_s5), .den(dn1_s5), .quo(r_lb));
	wep_satdiv #(.NW(PRW)) u_sd_rx (
		.clk(clk), .en(adv), .num(sxn2_s5), .den(sxd2_s5), .quo(r_rx));
	wep_satdiv #(.NW(PRW)) u_sd_rt (
		.clk(clk), .en(adv), .num(tn2_s5), .den(dn2_s5), .quo(r_rt));
	wep_satdiv #(.NW(PRW)) u_sd_rb (
		.clk(clk), .en(adv), .num(bn2_s5), .den(dn2_s5), .quo(r_rb));
endmodule
`default_nettype wire

@@ src/wep_checker.sv @@
// Port-level checks for the projection unit, bound to the top level.
// Depends on wep_pkg.
`default_nettype none
module wep_checker import wep_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       visible,
	input logic signed [SCR_W-1:0]    left_x,
	input logic signed [SCR_W-1:0]    right_x,
	input logic signed [SCR_W-1:0]    left_top,
	input logic signed [SCR_W-1:0]    left_bottom,
	input logic signed [SCR_W-1:0]    right_top,
	input logic signed [SCR_W-1:0]    right_bottom,
	input logic                       edge_last
);
	logic [9:0] pending_q;
	logic in_acc, out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(visible) && $stable(left_x)
			&& $stable(right_bottom) && $stable(edge_last))
		else $error("stalled result changed");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !visible |-> left_x == 0 && right_x == 0 && left_top == 0
			&& left_bottom == 0 && right_top == 0 && right_bottom == 0)
		else $error("hidden edge with nonzero screen fields");

	a_owed: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pending_q != 0)
		else $error("result without an outstanding edge");
endmodule

bind wall_edge_perspective_project_unit wep_checker u_chk (.*);
`default_nettype wire

@@ dv/testbench.sv @@
// Testbench for wall_edge_perspective_project_unit: directed and random wall edges
// are checked field by field against a wide-integer projection predictor or a fixed hidden result.
// Depends on wep_pkg and the unit's RTL only.
`timescale 1ns / 1ps
module testbench;
	import wep_pkg::*;

	localparam int SW = 320;
	localparam int SH = 200;
	localparam int SETTLE = 140;
	localparam int IDLE_LIMIT = 20000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(9);

	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic              visible;
		logic signed [15:0] lx, rx, lt, lb, rt, rb;
		logic              last;
	} screen_edge_t;

	typedef struct {
		logic [31:0] sx, sy, ex, ey, h;
		logic        last;
		logic        typed;
	} edge_row_t;

	logic clk = 0, arst_n = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic signed [31:0] start_x = 0, start_y = 0, end_x = 0, end_y = 0, wall_height = 0;
	logic last_edge = 0;
	logic visible, edge_last;
	logic signed [15:0] left_x, right_x, left_top, left_bottom, right_top, right_bottom;

	longint cam_x = 0, cam_y = 0, cam_cos = 16384, cam_sin = 0;
	screen_edge_t pending[$];
	int errors = 0;
	int idle_cycles = 0;
	bit calm = 0;

	wall_edge_perspective_project_unit dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic logic signed [15:0] sat_quot(wide_t n, wide_t d);
		wide_t q;
		if (d == 0)
			return (n == 0) ? 16'sd0 : ((n < 0) ? -16'sd32768 : 16'sd32767);
		q = n / d;
		if (q < -32768)
			return -16'sd32768;
		if (q > 32767)
			return 16'sd32767;
		return q[15:0];
	endfunction

	function automatic void side_hit(input wide_t ax, az, bx, bz,
			input longint cx, cz, dx, dz, output wide_t ox, oz);
		wide_t pab, pcd, ex, ez, fx, fz, det;
		pab = ax * bz - az * bx;
		pcd = wide_t'(cx) * wide_t'(dz) - wide_t'(cz) * wide_t'(dx);
		ex = ax - bx;
		ez = az - bz;
		fx = wide_t'(cx - dx);
		fz = wide_t'(cz - dz);
		det = ex * fz - ez * fx;
		if (det == 0) begin
			ox = 0;
			oz = 0;
		end else begin
			ox = (pab * fx - ex * pcd) / det;
			oz = (pab * fz - ez * pcd) / det;
		end
	endfunction

	function automatic void project_end(input wide_t x, z, hgt,
			output logic signed [15:0] px, top, bot);
		wide_t base, mid, den;
		base = wide_t'(2 * SW * SH) * wide_t'(65536);
		mid = wide_t'(60 * SH) * z;
		den = wide_t'(120) * z;
		px = sat_quot(wide_t'(SW) * (z - x), wide_t'(2) * z);
		top = sat_quot(wide_t'(120) * hgt - base + mid, den);
		bot = sat_quot(base + mid, den);
	endfunction

	function automatic screen_edge_t project_edge(edge_row_t r);
		screen_edge_t o;
		longint p1x, p1y, p2x, p2y, x1, z1, x2, z2;
		wide_t cr, hgt, X1, Z1, X2, Z2, l_x, l_z, r_x, r_z;
		o = '{default: 0};
		o.last = r.last;
		p1x = longint'(signed'(r.sx)) - cam_x;
		p1y = longint'(signed'(r.sy)) - cam_y;
		p2x = longint'(signed'(r.ex)) - cam_x;
		p2y = longint'(signed'(r.ey)) - cam_y;
		hgt = -wide_t'(signed'(r.h));
		cr = wide_t'(p1x) * wide_t'(p2y) - wide_t'(p1y) * wide_t'(p2x);
		if (cr >= (wide_t'(1) <<< 32))
			return o;
		z1 = (p1x * cam_cos + p1y * cam_sin) >>> 14;
		x1 = (p1x * cam_sin - p1y * cam_cos) >>> 14;
		z2 = (p2x * cam_cos + p2y * cam_sin) >>> 14;
		x2 = (p2x * cam_sin - p2y * cam_cos) >>> 14;
		if (z1 <= 0 && z2 <= 0)
			return o;
		X1 = x1; Z1 = z1; X2 = x2; Z2 = z2;
		side_hit(X1, Z1, X2, Z2, -7, 7, -20 * 65536, 5 * 65536, l_x, l_z);
		side_hit(X1, Z1, X2, Z2, 7, 7, 20 * 65536, 5 * 65536, r_x, r_z);
		if (z1 <= 0) begin
			X1 = (l_z > 0) ? l_x : r_x;
			Z1 = (l_z > 0) ? l_z : r_z;
		end
		if (z2 <= 0) begin
			X2 = (l_z > 0) ? l_x : r_x;
			Z2 = (l_z > 0) ? l_z : r_z;
		end
		o.visible = 1;
		project_end(X1, Z1, hgt, o.lx, o.lt, o.lb);
		project_end(X2, Z2, hgt, o.rx, o.rt, o.rb);
		return o;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(negedge clk)
		if (arst_n)
			out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 30 ? 1'b1 : 1'b0);

	always @(posedge clk) begin
		screen_edge_t w;
		if (out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				report("unexpected transaction", 0, 0);
			end else begin
				w = pending.pop_front();
				if (visible !== w.visible) report("visible", visible, w.visible);
				if (left_x !== w.lx) report("left_x", left_x, w.lx);
				if (right_x !== w.rx) report("right_x", right_x, w.rx);
				if (left_top !== w.lt) report("left_top", left_top, w.lt);
				if (left_bottom !== w.lb) report("left_bottom", left_bottom, w.lb);
				if (right_top !== w.rt) report("right_top", right_top, w.rt);
				if (right_bottom !== w.rb) report("right_bottom", right_bottom, w.rb);
				if (edge_last !== w.last) report("edge_last", edge_last, w.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_CAMERA_X: cam_x = longint'(signed'(val));
			REG_CAMERA_Y: cam_y = longint'(signed'(val));
			REG_COS: cam_cos = longint'(signed'(val[15:0]));
			REG_SIN: cam_sin = longint'(signed'(val[15:0]));
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic set_camera(input logic [31:0] px, py, input logic [15:0] c, s);
		write_reg(REG_CAMERA_X, px);
		write_reg(REG_CAMERA_Y, py);
		write_reg(REG_COS, {$urandom} << 16 | c);
		write_reg(REG_SIN, {16'h0, s});
	endtask

	task automatic send_edge(input edge_row_t r, input screen_edge_t typed_want);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1;
		start_x <= r.sx;
		start_y <= r.sy;
		end_x <= r.ex;
		end_y <= r.ey;
		wall_height <= r.h;
		last_edge <= r.last;
		do @(posedge clk); while (in_stall);
		pending.push_back(r.typed ? typed_want : project_edge(r));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [31:0] near_cam(longint c, int span);
		return 32'(c + $signed($urandom_range(0, 2 * span)) - span);
	endfunction

	task automatic random_edges(input int n);
		edge_row_t r;
		int kind, span;
		screen_edge_t none;
		none = '{default: 0};
		for (int i = 0; i < n; i++) begin
			if (i % 150 == 0)
				calm = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 99);
			span = 1 << $urandom_range(4, 23);
			r.sx = near_cam(cam_x, span);
			r.sy = near_cam(cam_y, span);
			r.ex = near_cam(cam_x, span);
			r.ey = near_cam(cam_y, span);
			r.h = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 22) - (1 << 20);
			r.last = $urandom_range(0, 1);
			r.typed = 0;
			if (kind < 15) begin
				r.sx = $urandom; r.sy = $urandom; r.ex = $urandom; r.ey = $urandom;
			end else if (kind < 20) begin
				r.ex = r.sx; r.ey = r.sy;
			end else if (kind < 25) begin
				r.ey = r.sy;
			end
			send_edge(r, none);
		end
		calm = 0;
	endtask

	edge_row_t directed[] = '{
		'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1},
		'{32'hFFFF0000, 32'h0, 32'hFFFF0000, 32'h0, 32'h10000, 1'b1, 1'b1},
		'{32'h10000, 32'h0, 32'h0, 32'h10000, 32'h10000, 1'b0, 1'b1},
		'{32'h7FFFFFFF, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 1'b1},
		'{32'h10000, 32'h10000, 32'h10000, 32'hFFFF0000, 32'h10000, 1'b0, 1'b0},
		'{32'h50000, 32'h30000, 32'h50000, 32'hFFFD0000, 32'h80000000, 1'b1, 1'b0},
		'{32'h50000, 32'h20000, 32'hFFFE0000, 32'hFFFB0000, 32'h7FFFFFFF, 1'b0, 1'b0},
		'{32'h0, 32'h30000, 32'h30000, 32'h0, 32'h20000, 1'b0, 1'b0},
		'{32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1'b1, 1'b0},
		'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b0, 1'b0},
		'{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h1, 1'b1, 1'b0},
		'{32'h4, 32'h3, 32'h4, 32'hFFFFFFFD, 32'h10000, 1'b0, 1'b0},
		'{32'h10000, 32'h4000, 32'hFFFF0000, 32'h8000, 32'h30000, 1'b0, 1'b0},
		'{32'hFFFF0000, 32'h10000, 32'h10000, 32'hFFFF0000, 32'h10000, 1'b1, 1'b0},
		'{32'hFFFF0000, 32'h40000, 32'hFFFF0000, 32'hFFFC0000, 32'h10000, 1'b0, 1'b0}
	};

	initial begin
		screen_edge_t want;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		foreach (directed[i]) begin
			want = '{default: 0};
			want.last = directed[i].last;
			send_edge(directed[i], want);
		end
		random_edges(300);
		drain();
		set_camera(32'h80000000, 32'h80000000, 16'hC000, 16'h4000);
		write_reg(REG_UNUSED, $urandom);
		random_edges(300);
		drain();
		set_camera(32'h7FFFFFFF, 32'h7FFFFFFF, 16'h4000, 16'hC000);
		random_edges(300);
		drain();
		set_camera($urandom_range(0, 1 << 22) - (1 << 21), $urandom, 16'd11585, 16'd11585);
		random_edges(300);
		drain();
		for (int p = 0; p < 3; p++) begin
			set_camera($urandom, $urandom, 16'($urandom_range(0, 32768) - 16384),
				16'($urandom_range(0, 32768) - 16384));
			random_edges(200);
			drain();
		end
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

@@ sim.f @@
src/wep_pkg.sv
src/wep_fifo.sv
src/wep_front.sv
src/wep_sdiv.sv
src/wep_satdiv.sv
src/wep_back.sv
src/wall_edge_perspective_project_unit.sv
src/wep_checker.sv
dv/testbench.sv
